FILE: rtl/pst_pkg.sv
// Package for the prefix sum tree: sizes, item kinds, register indexes and the
// command/status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package pst_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int ADDR_W        = $clog2(MAX_POSITIONS);
   localparam int INDEX_W       = 11;
   localparam int POS_W         = INDEX_W + 1;
   localparam int DATA_W        = 32;
   localparam int KIND_W        = 2;
   localparam int SIZE_W        = 11;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_IDX_W     = CSR_ADDR_W - 2;

   localparam logic [SIZE_W-1:0]    SIZE_RESET = SIZE_W'(1024);
   localparam logic [INDEX_W-1:0]   MAX_BOUND  = INDEX_W'(MAX_POSITIONS);
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SIZE_IN_USE = CSR_IDX_W'(0);

   typedef enum logic [KIND_W-1:0] {
      KIND_POINT_ADD  = 2'd0,
      KIND_RANGE_ADD  = 2'd1,
      KIND_PREFIX_SUM = 2'd2,
      KIND_RANGE_SUM  = 2'd3
   } pst_kind_type;

   typedef struct packed {
      logic load_a;      // accept a word, start the first walk
      logic load_b;      // start the second walk
      logic clear_step;  // zero one memory entry
      logic load_rsp;    // capture the accumulated sum into the output register
   } pst_cmd_type;

   typedef struct packed {
      logic walk_done;
      logic clear_last;
      logic second_walk;
      logic has_result;
   } pst_sts_type;

endpackage

`default_nettype wire

FILE: rtl/pst_req_if.sv
// Input channel of the prefix sum tree: valid/ready plus one item.
// Depends on pst_pkg.
`default_nettype none

interface pst_req_if;
   import pst_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic [INDEX_W-1:0]         first_index;
   logic [INDEX_W-1:0]         second_index;
   logic signed [DATA_W-1:0]   add_value;

   modport source (output valid, kind, first_index, second_index, add_value, input ready);
   modport sink   (input valid, kind, first_index, second_index, add_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/pst_rsp_if.sv
// Result channel of the prefix sum tree: valid/ready plus one sum.
// Depends on pst_pkg.
`default_nettype none

interface pst_rsp_if;
   import pst_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   sum;

   modport source (output valid, sum, input ready);
   modport sink   (input valid, sum, output ready);
endinterface

`default_nettype wire

FILE: rtl/pst_datapath.sv
// Datapath of the prefix sum tree: partial-sum memory, walk index, read
// pipeline, accumulator, clearing counter and output sum register.
// Depends on pst_pkg.
`default_nettype none

module pst_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire pst_pkg::pst_cmd_type             cmd,
   input  wire logic [pst_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [pst_pkg::INDEX_W-1:0]      req_first_index,
   input  wire logic [pst_pkg::INDEX_W-1:0]      req_second_index,
   input  wire logic signed [pst_pkg::DATA_W-1:0] req_add_value,
   input  wire logic [pst_pkg::SIZE_W-1:0]       size_in_use,
   output pst_pkg::pst_sts_type                  sts,
   output logic signed [pst_pkg::DATA_W-1:0]     rsp_sum
);
   import pst_pkg::*;

   logic [DATA_W-1:0]  mem [MAX_POSITIONS];

   pst_kind_type       kind_ff;
   logic [POS_W-1:0]   start_b_ff;
   logic [DATA_W-1:0]  value_ff;
   logic [POS_W-1:0]   pos_ff;
   logic               walk_b_ff;
   logic               stage_ff;
   logic [ADDR_W-1:0]  stage_addr_ff;
   logic [DATA_W-1:0]  rdata_ff;
   logic [DATA_W-1:0]  acc_ff;
   logic [DATA_W-1:0]  sum_ff;
   logic [ADDR_W-1:0]  clr_cnt_ff;

   logic [INDEX_W-1:0] bound;
   logic [INDEX_W-1:0] first_minus;
   logic [POS_W-1:0]   start_a;
   logic [POS_W-1:0]   start_b;
   logic [POS_W-1:0]   low_bit;
   logic [POS_W-1:0]   pos_in;
   logic [ADDR_W-1:0]  rd_addr;
   logic [DATA_W-1:0]  amount;
   logic               is_update;
   logic               active;

   function automatic logic [INDEX_W-1:0] clamp(input logic [INDEX_W-1:0] x,
                                                input logic [INDEX_W-1:0] b);
      return (x > b) ? b : x;
   endfunction

   assign bound       = (size_in_use > MAX_BOUND) ? MAX_BOUND : size_in_use;
   assign first_minus = (req_first_index == '0) ? '0 : req_first_index - INDEX_W'(1);

   // Range sum adds prefix(j) then takes away prefix(i-1); range add
   // climbs from i with +v, then from j+1 with -v.
   always_comb begin
      unique case (pst_kind_type'(req_kind))
         KIND_POINT_ADD: begin
            start_a = {1'b0, req_first_index};
            start_b = '0;
         end
         KIND_RANGE_ADD: begin
            start_a = {1'b0, req_first_index};
            start_b = {1'b0, req_second_index} + POS_W'(1);
         end
         KIND_PREFIX_SUM: begin
            start_a = {1'b0, clamp(req_first_index, bound)};
            start_b = '0;
         end
         KIND_RANGE_SUM: begin
            start_a = {1'b0, clamp(req_second_index, bound)};
            start_b = {1'b0, clamp(first_minus, bound)};
         end
      endcase
   end

   assign is_update = (kind_ff == KIND_POINT_ADD) || (kind_ff == KIND_RANGE_ADD);
   assign active    = (pos_ff != '0) && (pos_ff <= {1'b0, bound});
   assign low_bit   = pos_ff & (~pos_ff + POS_W'(1));
   assign pos_in    = is_update ? pos_ff + low_bit : pos_ff - low_bit;
   assign rd_addr   = ADDR_W'(pos_ff - POS_W'(1));
   assign amount    = walk_b_ff ? (~value_ff + DATA_W'(1)) : value_ff;

   // walk control; drop a finished walk's index so a later bound cannot revive it
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         walk_b_ff  <= 1'b0;
         stage_ff   <= 1'b0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.load_a) begin
            pos_ff    <= start_a;
            walk_b_ff <= 1'b0;
         end else if (cmd.load_b) begin
            pos_ff    <= start_b_ff;
            walk_b_ff <= 1'b1;
         end else if (active) begin
            pos_ff <= pos_in;
         end else begin
            pos_ff <= '0;
         end
         stage_ff <= active;
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
      end
   end

   // item payload, accumulator and output sum
   always_ff @(posedge clock) begin
      stage_addr_ff <= rd_addr;
      if (cmd.load_a) begin
         kind_ff    <= pst_kind_type'(req_kind);
         start_b_ff <= start_b;
         value_ff   <= req_add_value;
         acc_ff     <= '0;
      end else if (stage_ff && !is_update) begin
         acc_ff <= walk_b_ff ? acc_ff - rdata_ff : acc_ff + rdata_ff;
      end
      if (cmd.load_rsp) begin
         sum_ff <= acc_ff;
      end
   end

   // partial-sum memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clr_cnt_ff] <= '0;
      end else if (stage_ff && is_update) begin
         mem[stage_addr_ff] <= rdata_ff + amount;
      end
      if (active) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign sts.walk_done   = !active && !stage_ff;
   assign sts.clear_last  = (clr_cnt_ff == ADDR_W'(MAX_POSITIONS - 1));
   assign sts.second_walk = (kind_ff == KIND_RANGE_ADD) || (kind_ff == KIND_RANGE_SUM);
   assign sts.has_result  = (kind_ff == KIND_PREFIX_SUM) || (kind_ff == KIND_RANGE_SUM);
   assign rsp_sum         = sum_ff;

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_a |-> sts.walk_done)
      else $error("walk restarted while the previous one was in flight");

   a_clear_no_write: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !stage_ff)
      else $error("clearing pass collides with a tree update");

   a_update_climbs: assert property (@(posedge clock) disable iff (reset)
      (stage_ff && active && is_update) |-> (rd_addr > stage_addr_ff))
      else $error("update walk read does not lie above the pending write");

endmodule

`default_nettype wire

FILE: rtl/pst_ctrl.sv
// Controller of the prefix sum tree: clearing pass, walk sequencing and the
// output valid flag. Depends on pst_pkg.
`default_nettype none

module pst_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire pst_pkg::pst_sts_type sts,
   output pst_pkg::pst_cmd_type      cmd
);
   import pst_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_WALK_A = 4'b0100,
      ST_WALK_B = 4'b1000
   } pst_state_type;

   pst_state_type state_ff;
   pst_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_a = 1'b1;
               state_in   = ST_WALK_A;
            end
         end
         ST_WALK_A: begin
            if (sts.walk_done) begin
               priority if (sts.second_walk) begin
                  cmd.load_b = 1'b1;
                  state_in   = ST_WALK_B;
               end else if (!sts.has_result) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_WALK_B: begin
            if (sts.walk_done) begin
               priority if (!sts.has_result) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  cmd.load_rsp = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // hold the result until taken
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_second_after_first: assert property (@(posedge clock) disable iff (reset)
      cmd.load_b |-> (state_ff == ST_WALK_A) && sts.walk_done)
      else $error("second walk started before the first finished");

   a_quiet_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result offered during the clearing pass");

endmodule

`default_nettype wire

FILE: rtl/prefix_sum_tree_top.sv
// Top level of the prefix sum tree: APB-style register port, controller and
// datapath. Depends on pst_pkg, pst_req_if, pst_rsp_if, pst_ctrl, pst_datapath.
//
// Use: each word on req_ch is one item: point add, range add, prefix sum or
// range sum over a binary indexed tree of 32-bit wrapping partial sums held
// in a 1024-word memory with one read and one write port. Sum items give one
// word on rsp_ch; add items give none. size_in_use (register 0, byte address
// 0) bounds the tree.
// Sequence: an item is accepted, then each walk visits its tree entries,
// drains the read/add pipeline and hands over. A walk visits at most 11
// entries; range items do two walks, one memory read per cycle while a walk
// runs. The sum goes into the output register, and so onto rsp_ch, once
// the last walk drains and that register is free.
// Reset: the memory is zeroed by a pass over all 1024 entries, one entry a cycle;
// req_ch.ready stays low meanwhile, register writes are taken throughout.
// Stall: a finished sum waits in the output register while the next item is
// taken; a further sum waits in the accumulator until that register frees.
`default_nettype none

module prefix_sum_tree_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   pst_req_if.sink                               req_ch,
   pst_rsp_if.source                             rsp_ch,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [pst_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [pst_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pst_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import pst_pkg::*;

   pst_cmd_type             cmd;
   pst_sts_type             sts;
   logic [SIZE_W-1:0]       size_ff;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic                    csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_write && (csr_index == CSR_IDX_SIZE_IN_USE)) begin
         size_ff <= pwdata[SIZE_W-1:0];
      end
   end

   assign prdata = (csr_index == CSR_IDX_SIZE_IN_USE) ? CSR_DATA_W'(size_ff) : '0;

   pst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pst_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_kind         (req_ch.kind),
      .req_first_index  (req_ch.first_index),
      .req_second_index (req_ch.second_index),
      .req_add_value    (req_ch.add_value),
      .size_in_use      (size_ff),
      .sts              (sts),
      .rsp_sum          (rsp_ch.sum)
   );

endmodule

`default_nettype wire

FILE: sim/tb_prefix_sum_tree_top.sv
// Testbench for prefix_sum_tree_top: drives add and sum words, predicts every sum
// with its own copy of the tree and compares each result word. Depends on pst_pkg,
// pst_req_if, pst_rsp_if and the block's RTL.
`timescale 1ns / 100ps

module tb_prefix_sum_tree_top;
   import pst_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_PERCENT = 19;

   typedef struct {
      pst_kind_type        kind;
      logic [INDEX_W-1:0]  first_index;
      logic [INDEX_W-1:0]  second_index;
      logic [DATA_W-1:0]   add_value;
   } tree_op_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   pst_req_if req_ch ();
   pst_rsp_if rsp_ch ();

   prefix_sum_tree_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow of the tree and its bound
   logic [DATA_W-1:0] partial_sums [1:MAX_POSITIONS];
   logic [SIZE_W-1:0] size_shadow;

   tree_op_t          pending_ops[$];
   logic [DATA_W-1:0] expected_sums[$];
   int unsigned       words_queued = 0;
   int unsigned       words_taken = 0;
   int unsigned       error_count = 0;
   int unsigned       cycle_count = 0;
   bit                calm = 1'b0;

   always #5 clock = ~clock;

   function automatic int unsigned tree_bound();
      return (size_shadow > MAX_POSITIONS) ? MAX_POSITIONS : int'(size_shadow);
   endfunction

   function automatic void tree_climb_add(int unsigned pos, logic [DATA_W-1:0] amount);
      int unsigned n;
      n = tree_bound();
      if (pos == 0) return;
      while (pos <= n) begin
         partial_sums[pos] += amount;
         pos += pos & (~pos + 1);
      end
   endfunction

   function automatic logic [DATA_W-1:0] tree_prefix(int unsigned pos);
      int unsigned n;
      logic [DATA_W-1:0] acc;
      n = tree_bound();
      acc = '0;
      if (pos > n) pos = n;
      while (pos > 0) begin
         acc += partial_sums[pos];
         pos -= pos & (~pos + 1);
      end
      return acc;
   endfunction

   // Apply one accepted word to the shadow tree, queue its sum if it has one
   function automatic void apply_tree_op(pst_kind_type kind, int unsigned i, int unsigned j,
                                         logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] low;
      case (kind)
         KIND_POINT_ADD: tree_climb_add(i, v);
         KIND_RANGE_ADD: begin
            tree_climb_add(i, v);
            tree_climb_add(j + 1, -v);
         end
         KIND_PREFIX_SUM: expected_sums.push_back(tree_prefix(i));
         default: begin
            low = (i == 0) ? '0 : tree_prefix(i - 1);
            expected_sums.push_back(tree_prefix(j) - low);
         end
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index(int unsigned bound);
      int unsigned r, eff;
      r = $urandom_range(99);
      eff = (bound > MAX_POSITIONS) ? MAX_POSITIONS : bound;
      if (r < 10) return INDEX_W'($urandom_range(2047));
      if (r < 20) begin
         case ($urandom_range(3))
            0: return '0;
            1: return INDEX_W'(1);
            2: return INDEX_W'(bound);
            default: return INDEX_W'(bound + 1);
         endcase
      end
      return INDEX_W'($urandom_range(eff + 1));
   endfunction

   function automatic logic [DATA_W-1:0] pick_amount();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3, 4: return DATA_W'($urandom_range(20)) - 32'd10;
         default: return $urandom();
      endcase
   endfunction

   function automatic void queue_op(pst_kind_type kind, int unsigned i, int unsigned j,
                                    logic [DATA_W-1:0] v);
      tree_op_t op;
      op.kind = kind;
      op.first_index = INDEX_W'(i);
      op.second_index = INDEX_W'(j);
      op.add_value = v;
      pending_ops.push_back(op);
      words_queued++;
   endfunction

   task automatic write_size(int unsigned value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {CSR_IDX_SIZE_IN_USE, 2'b00};
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      size_shadow = SIZE_W'(value);
   endtask

   // Hold until every word is taken and every sum has come back, then let adds settle
   task automatic wait_idle();
      do @(posedge clock); while (words_taken != words_queued || expected_sums.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver
   always @(posedge clock) begin
      bit lull;
      tree_op_t op;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            apply_tree_op(pst_kind_type'(req_ch.kind), req_ch.first_index,
                          req_ch.second_index, req_ch.add_value);
            words_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            lull = !calm && ($urandom_range(99) < IDLE_PERCENT);
            if (pending_ops.size() != 0 && !lull) begin
               op = pending_ops.pop_front();
               req_ch.kind <= op.kind;
               req_ch.first_index <= op.first_index;
               req_ch.second_index <= op.second_index;
               req_ch.add_value <= op.add_value;
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      logic [DATA_W-1:0] want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_sums.size() == 0) begin
               $display("%0t: unexpected sum word, expected none, got %h", $time, rsp_ch.sum);
               error_count++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_ch.sum !== want) begin
                  $display("%0t: sum mismatch, expected %h, got %h", $time, want, rsp_ch.sum);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d sums outstanding", $time,
                  expected_sums.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned phase_sizes[10];
      int unsigned bound;
      pst_kind_type kind;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_POINT_ADD;
      req_ch.first_index = '0;
      req_ch.second_index = '0;
      req_ch.add_value = '0;
      rsp_ch.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      foreach (partial_sums[k]) partial_sums[k] = '0;
      size_shadow = SIZE_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words at full size
      write_size(MAX_POSITIONS);
      queue_op(KIND_POINT_ADD, 1, 0, 32'h7FFF_FFFF);
      queue_op(KIND_POINT_ADD, 1024, 0, 32'h8000_0000);
      queue_op(KIND_POINT_ADD, 0, 0, 32'd5);          // index zero: dropped
      queue_op(KIND_POINT_ADD, 2047, 2047, 32'd7);    // past the bound: dropped
      queue_op(KIND_RANGE_ADD, 3, 10, 32'd100);
      queue_op(KIND_RANGE_ADD, 0, 5, 32'hFFFF_FFFF);
      queue_op(KIND_RANGE_ADD, 500, 1024, 32'hFFFF_FFFF);
      queue_op(KIND_RANGE_ADD, 2047, 2047, 32'd3);
      queue_op(KIND_PREFIX_SUM, 0, 0, '0);
      queue_op(KIND_PREFIX_SUM, 1, 2047, 32'hFFFF_FFFF);
      queue_op(KIND_PREFIX_SUM, 5, 0, '0);
      queue_op(KIND_PREFIX_SUM, 1023, 0, '0);
      queue_op(KIND_PREFIX_SUM, 1024, 0, '0);
      queue_op(KIND_PREFIX_SUM, 2047, 0, '0);
      queue_op(KIND_RANGE_SUM, 0, 1024, '0);
      queue_op(KIND_RANGE_SUM, 10, 3, '0);
      queue_op(KIND_RANGE_SUM, 3, 10, '0);
      queue_op(KIND_RANGE_SUM, 1, 1, '0);
      queue_op(KIND_RANGE_SUM, 1024, 1024, '0);
      queue_op(KIND_RANGE_SUM, 2047, 2047, '0);
      queue_op(KIND_POINT_ADD, 512, 0, 32'd1);
      queue_op(KIND_PREFIX_SUM, 512, 0, '0);
      wait_idle();

      phase_sizes = '{1, 2047, 0, 2, 7, 1000, 1024, 64, 1, 1024};
      phase_sizes[7] = $urandom_range(1, MAX_POSITIONS);
      foreach (phase_sizes[p]) begin
         bound = phase_sizes[p];
         write_size(bound);
         calm = (p == 5);
         repeat (195) begin
            kind = pst_kind_type'($urandom_range(3));
            queue_op(kind, pick_index(bound), pick_index(bound), pick_amount());
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
